### hdl/iul_pkg.sv
// Package for the integer upscale letterbox core.
// Holds frame constants, field widths, register indexes, controller types and the fit function.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package iul_pkg;

  localparam int OUT_WIDTH  = 1280;
  localparam int OUT_HEIGHT = 720;
  localparam int MAX_FACTOR = 8;

  localparam int COL_W    = 11;
  localparam int ROW_W    = 10;
  localparam int COLOR_W  = 16;
  localparam int FACTOR_W = $clog2(MAX_FACTOR + 1);
  localparam int POSX_W   = 16;
  localparam int POSY_W   = 15;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_ASPECT_LOCK   = 2'd0,
    REG_SOURCE_WIDTH  = 2'd1,
    REG_SOURCE_HEIGHT = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FACTOR,
    S_PRODUCT,
    S_BASE,
    S_COUNT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic factor;
    logic product;
    logic base;
    logic count;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic last;
  } dp_status_t;

  // Fit factor limited to 1..MAX_FACTOR: one plus the number of factors
  // from two upward whose scaled size still fits the frame.
  function automatic logic [FACTOR_W-1:0] fit_factor(input logic [POSX_W-1:0] size,
                                                     input logic [POSX_W-1:0] frame);
    logic [FACTOR_W-1:0] n;
    n = FACTOR_W'(1);
    for (int f = 2; f <= MAX_FACTOR; f++) begin
      if (size * POSX_W'(f) <= frame) begin
        n = n + 1'b1;
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

### hdl/iul_regs.sv
// Configuration register file of the integer upscale letterbox core.
// APB-style write and read access to aspect lock and the source frame size.
// Depends on iul_pkg.
`default_nettype none

module iul_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [iul_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [iul_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [iul_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                  pready,
  output logic                                  aspect_lock,
  output logic      [iul_pkg::COL_W-1:0]        source_width,
  output logic      [iul_pkg::ROW_W-1:0]        source_height
);
  import iul_pkg::*;

  reg_index_t index;
  logic       wr_en;

  assign index  = reg_index_t'(paddr[APB_ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      aspect_lock   <= 1'b0;
      source_width  <= COL_W'(320);
      source_height <= ROW_W'(240);
    end else if (wr_en) begin
      unique case (index)
        REG_ASPECT_LOCK:   aspect_lock   <= pwdata[0];
        REG_SOURCE_WIDTH:  source_width  <= pwdata[COL_W-1:0];
        REG_SOURCE_HEIGHT: source_height <= pwdata[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      REG_ASPECT_LOCK:   prdata = APB_DATA_W'(aspect_lock);
      REG_SOURCE_WIDTH:  prdata = APB_DATA_W'(source_width);
      REG_SOURCE_HEIGHT: prdata = APB_DATA_W'(source_height);
      default:           prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### hdl/iul_ctrl.sv
// Controller of the integer upscale letterbox core.
// Sequences factor, product, base and count steps, then paces the write loop.
// Depends on iul_pkg.
`default_nettype none

module iul_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output iul_pkg::dp_cmd_t           cmd,
  input  wire iul_pkg::dp_status_t   status
);
  import iul_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_FACTOR;
        end
      end
      S_FACTOR: begin
        cmd.factor = 1'b1;
        state_next = S_PRODUCT;
      end
      S_PRODUCT: begin
        cmd.product = 1'b1;
        state_next  = S_BASE;
      end
      S_BASE: begin
        cmd.base   = 1'b1;
        state_next = S_COUNT;
      end
      S_COUNT: begin
        cmd.count  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.empty) begin
          state_next = S_IDLE;
        end else begin
          out_valid = 1'b1;
          if (out_ready) begin
            cmd.step = 1'b1;
            if (status.last) begin
              state_next = S_IDLE;
            end
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### hdl/iul_datapath.sv
// Datapath of the integer upscale letterbox core.
// Holds the word, the factors, offsets, start position and the replica counters.
// Depends on iul_pkg.
`default_nettype none

module iul_datapath (
  input  wire logic                          clk,
  input  wire logic                          aspect_lock,
  input  wire logic [iul_pkg::COL_W-1:0]     source_width,
  input  wire logic [iul_pkg::ROW_W-1:0]     source_height,
  input  wire logic [iul_pkg::COL_W-1:0]     column,
  input  wire logic [iul_pkg::ROW_W-1:0]     row,
  input  wire logic [iul_pkg::COLOR_W-1:0]   color,
  input  wire iul_pkg::dp_cmd_t              cmd,
  output iul_pkg::dp_status_t                status,
  output logic      [iul_pkg::COL_W-1:0]     out_x,
  output logic      [iul_pkg::ROW_W-1:0]     out_y,
  output logic      [iul_pkg::COLOR_W-1:0]   out_color,
  output logic                               final_res
);
  import iul_pkg::*;

  localparam logic [POSX_W-1:0] FRAME_X = POSX_W'(OUT_WIDTH);
  localparam logic [POSY_W-1:0] FRAME_Y = POSY_W'(OUT_HEIGHT);

  logic [COL_W-1:0]    col_q;
  logic [ROW_W-1:0]    row_q;
  logic [COL_W-1:0]    sw_eff;
  logic [ROW_W-1:0]    sh_eff;
  logic [FACTOR_W-1:0] fit_x;
  logic [FACTOR_W-1:0] fit_y;
  logic [FACTOR_W-1:0] fx;
  logic [FACTOR_W-1:0] fy;
  logic [POSX_W-1:0]   used_x;
  logic [POSY_W-1:0]   used_y;
  logic [POSX_W-1:0]   col_scaled;
  logic [POSY_W-1:0]   row_scaled;
  logic [POSX_W-1:0]   off_x;
  logic [POSY_W-1:0]   off_y;
  logic [POSX_W-1:0]   x0;
  logic [POSY_W-1:0]   y0;
  logic [POSX_W-1:0]   room_x;
  logic [POSY_W-1:0]   room_y;
  logic [FACTOR_W-1:0] nx;
  logic [FACTOR_W-1:0] ny;
  logic [FACTOR_W-1:0] nx_next;
  logic [FACTOR_W-1:0] ny_next;
  logic [FACTOR_W-1:0] rx;
  logic [FACTOR_W-1:0] ry;
  logic [COL_W-1:0]    x_start;
  logic                row_end;

  assign sw_eff = (source_width == '0) ? COL_W'(1) : source_width;
  assign sh_eff = (source_height == '0) ? ROW_W'(1) : source_height;
  assign fit_x  = fit_factor(POSX_W'(sw_eff), FRAME_X);
  assign fit_y  = fit_factor(POSX_W'(sh_eff), POSX_W'(OUT_HEIGHT));

  assign off_x  = (used_x >= FRAME_X) ? '0 : ((FRAME_X - used_x) >> 1);
  assign off_y  = (used_y >= FRAME_Y) ? '0 : ((FRAME_Y - used_y) >> 1);

  assign room_x  = FRAME_X - x0;
  assign room_y  = FRAME_Y - y0;
  assign nx_next = (x0 >= FRAME_X) ? '0 :
                   (room_x < POSX_W'(fx)) ? room_x[FACTOR_W-1:0] : fx;
  assign ny_next = (y0 >= FRAME_Y) ? '0 :
                   (room_y < POSY_W'(fy)) ? room_y[FACTOR_W-1:0] : fy;

  assign row_end      = (rx == nx - 1'b1);
  assign status.empty = (nx == '0) || (ny == '0);
  assign status.last  = row_end && (ry == ny - 1'b1);
  assign final_res    = status.last;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_q     <= column;
      row_q     <= row;
      out_color <= color;
    end
    if (cmd.factor) begin
      if (aspect_lock) begin
        fx <= (fit_x < fit_y) ? fit_x : fit_y;
        fy <= (fit_x < fit_y) ? fit_x : fit_y;
      end else begin
        fx <= fit_x;
        fy <= fit_y;
      end
    end
    if (cmd.product) begin
      used_x     <= POSX_W'(sw_eff) * POSX_W'(fx);
      used_y     <= POSY_W'(sh_eff) * POSY_W'(fy);
      col_scaled <= POSX_W'(col_q) * POSX_W'(fx);
      row_scaled <= POSY_W'(row_q) * POSY_W'(fy);
    end
    if (cmd.base) begin
      x0 <= off_x + col_scaled;
      y0 <= off_y + row_scaled;
    end
    if (cmd.count) begin
      nx      <= nx_next;
      ny      <= ny_next;
      rx      <= '0;
      ry      <= '0;
      x_start <= x0[COL_W-1:0];
      out_x   <= x0[COL_W-1:0];
      out_y   <= y0[ROW_W-1:0];
    end else if (cmd.step) begin
      if (row_end) begin
        rx    <= '0;
        ry    <= ry + 1'b1;
        out_x <= x_start;
        out_y <= out_y + 1'b1;
      end else begin
        rx    <= rx + 1'b1;
        out_x <= out_x + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/integer_upscale_letterbox_core.sv
// Top level of the integer upscale letterbox core.
// Joins the register file, the controller and the datapath.
// Depends on iul_pkg, iul_regs, iul_ctrl and iul_datapath.
//
// A source pixel word (column, row, color) enters on the in_valid/in_ready
// channel. The block replicates it into factor_x by factor_y destination
// words on the out_valid/out_ready channel, row of replicas by row, and
// drops the ones that fall off the 1280 by 720 frame. final_res marks the
// last word sent for a pixel; a pixel whose writes all fall off sends none.
// Factors and centering offsets follow the aspect_lock, source_width and
// source_height registers, which must be written over the APB-style port
// only while idle; the user is bound by this, and the block itself does not
// enforce it. One pixel is taken at a time. After acceptance, the setup
// steps for factors, products, offsets and counts precede the first word,
// and then one word leaves per cycle while out_ready is high.
// A stalled receiver holds the current word and freezes the replica loop.
// Reset returns the registers to stretch mode, 320 by 240, and the
// controller to idle with no word pending.
`default_nettype none

module integer_upscale_letterbox_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [iul_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [iul_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [iul_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                  pready,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [iul_pkg::COL_W-1:0]        column,
  input  wire logic [iul_pkg::ROW_W-1:0]        row,
  input  wire logic [iul_pkg::COLOR_W-1:0]      color,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic      [iul_pkg::COL_W-1:0]        out_x,
  output logic      [iul_pkg::ROW_W-1:0]        out_y,
  output logic      [iul_pkg::COLOR_W-1:0]      out_color,
  output logic                                  final_res
);
  import iul_pkg::*;

  logic               aspect_lock;
  logic [COL_W-1:0]   source_width;
  logic [ROW_W-1:0]   source_height;
  dp_cmd_t            cmd;
  dp_status_t         status;

  iul_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .aspect_lock   (aspect_lock),
    .source_width  (source_width),
    .source_height (source_height)
  );

  iul_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  iul_datapath u_datapath (
    .clk           (clk),
    .aspect_lock   (aspect_lock),
    .source_width  (source_width),
    .source_height (source_height),
    .column        (column),
    .row           (row),
    .color         (color),
    .cmd           (cmd),
    .status        (status),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_color     (out_color),
    .final_res     (final_res)
  );

endmodule

`default_nettype wire

### dv/tb.sv
// Testbench for integer_upscale_letterbox_core: drives source pixels and register writes,
// predicts every replicated destination write and checks them in order.
// Depends on iul_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb;
  import iul_pkg::*;

  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 12;

  typedef struct packed {
    logic [COL_W-1:0]   x;
    logic [ROW_W-1:0]   y;
    logic [COLOR_W-1:0] rgb;
    logic               last;
  } dest_write_t;

  class letterbox_writes;
    logic               aspect_lock;
    logic [COL_W-1:0]   source_width;
    logic [ROW_W-1:0]   source_height;
    dest_write_t        pending[$];
    int                 errors;

    function new();
      aspect_lock   = 1'b0;
      source_width  = COL_W'(320);
      source_height = ROW_W'(240);
      errors        = 0;
    endfunction

    function void set_reg(reg_index_t idx, logic [APB_DATA_W-1:0] value);
      case (idx)
        REG_ASPECT_LOCK:   aspect_lock   = value[0];
        REG_SOURCE_WIDTH:  source_width  = value[COL_W-1:0];
        REG_SOURCE_HEIGHT: source_height = value[ROW_W-1:0];
        default: ;
      endcase
    endfunction

    static function int axis_fit(int frame, int size);
      int f;
      f = frame / size;
      return (f < 1) ? 1 : f;
    endfunction

    static function int center(int frame, int used);
      return (used >= frame) ? 0 : (frame - used) / 2;
    endfunction

    function void note_pixel(logic [COL_W-1:0] c, logic [ROW_W-1:0] r,
                             logic [COLOR_W-1:0] rgb);
      int sw, sh, fx, fy, ox, oy, x, y, before_cnt;
      dest_write_t w;
      sw = (source_width == 0) ? 1 : int'(source_width);
      sh = (source_height == 0) ? 1 : int'(source_height);
      if (aspect_lock) begin
        fy = axis_fit(OUT_HEIGHT, sh);
        if (sw * fy > OUT_WIDTH) begin
          fy = axis_fit(OUT_WIDTH, sw);
        end
        fx = fy;
      end else begin
        fx = axis_fit(OUT_WIDTH, sw);
        fy = axis_fit(OUT_HEIGHT, sh);
      end
      if (fx > MAX_FACTOR) fx = MAX_FACTOR;
      if (fy > MAX_FACTOR) fy = MAX_FACTOR;
      ox = center(OUT_WIDTH, sw * fx);
      oy = center(OUT_HEIGHT, sh * fy);
      before_cnt = pending.size();
      for (int ry = 0; ry < fy; ry++) begin
        y = oy + int'(r) * fy + ry;
        if (y < OUT_HEIGHT) begin
          for (int rx = 0; rx < fx; rx++) begin
            x = ox + int'(c) * fx + rx;
            if (x < OUT_WIDTH) begin
              w.x    = COL_W'(x);
              w.y    = ROW_W'(y);
              w.rgb  = rgb;
              w.last = 1'b0;
              pending.push_back(w);
            end
          end
        end
      end
      if (pending.size() > before_cnt) begin
        pending[pending.size() - 1].last = 1'b1;
      end
    endfunction

    function void check_write(dest_write_t got);
      dest_write_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected write: expected none, got x=%0d y=%0d color=%h last=%0b",
                 $time, got.x, got.y, got.rgb, got.last);
      end else begin
        want = pending.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.rgb !== want.rgb ||
            got.last !== want.last) begin
          errors++;
          $display("%0t: write mismatch: expected x=%0d y=%0d color=%h last=%0b,",
                   $time, want.x, want.y, want.rgb, want.last);
          $display("%0t:   got x=%0d y=%0d color=%h last=%0b",
                   $time, got.x, got.y, got.rgb, got.last);
        end
      end
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [APB_ADDR_W-1:0] paddr     = '0;
  logic [APB_DATA_W-1:0] pwdata    = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic [COL_W-1:0]      column    = '0;
  logic [ROW_W-1:0]      row       = '0;
  logic [COLOR_W-1:0]    color     = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [COL_W-1:0]      out_x;
  logic [ROW_W-1:0]      out_y;
  logic [COLOR_W-1:0]    out_color;
  logic                  final_res;

  letterbox_writes frame_writes;
  bit              tx_calm = 1'b0;
  bit              rx_calm = 1'b0;
  int              quiet_cycles = 0;

  integer_upscale_letterbox_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .column    (column),
    .row       (row),
    .color     (color),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_color (out_color),
    .final_res (final_res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        frame_writes.check_write({out_x, out_y, out_color, final_res});
      end
      if (in_valid && in_ready) begin
        frame_writes.note_pixel(column, row, color);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int stall;
    @(negedge rst);
    forever begin
      stall = rx_calm ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic write_reg(input reg_index_t idx, input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(int'(idx) * 4);
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    frame_writes.set_reg(idx, APB_DATA_W'(value));
    @(posedge clk);
  endtask

  task automatic set_mode(input int lock, input int sw, input int sh);
    write_reg(REG_ASPECT_LOCK, lock);
    write_reg(REG_SOURCE_WIDTH, sw);
    write_reg(REG_SOURCE_HEIGHT, sh);
  endtask

  task automatic send_pixel(input int c, input int r, input int rgb);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    column   <= COL_W'(c);
    row      <= ROW_W'(r);
    color    <= COLOR_W'(rgb);
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_writes();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frame_writes.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic int draw_size(int limit, int top);
    case ($urandom_range(0, 7))
      0: return $urandom_range(1, 16);
      1: begin
        case ($urandom_range(0, 3))
          0: return 0;
          1: return 1;
          2: return limit;
          default: return top;
        endcase
      end
      2: return $urandom_range(1, 400);
      default: return $urandom_range(1, limit);
    endcase
  endfunction

  task automatic random_pixel();
    int w, h;
    w = (frame_writes.source_width == 0) ? 1 : int'(frame_writes.source_width);
    h = (frame_writes.source_height == 0) ? 1 : int'(frame_writes.source_height);
    if ($urandom_range(0, 7) == 0) begin
      send_pixel($urandom_range(0, 2047), $urandom_range(0, 1023), $urandom_range(0, 65535));
    end else begin
      send_pixel($urandom_range(0, w - 1), $urandom_range(0, h - 1),
                 $urandom_range(0, 65535));
    end
  endtask

  initial begin
    frame_writes = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset setting: stretch mode at 320 by 240, including words that fall off the frame.
    send_pixel(0, 0, 16'h0000);
    send_pixel(319, 239, 16'hFFFF);
    send_pixel(320, 0, 16'hA5A5);
    send_pixel(2047, 1023, 16'h5A5A);
    send_pixel(0, 240, 16'h0F0F);
    drain_writes();

    // One-pixel source: both factors saturate and the right and bottom edges clip.
    set_mode(1, 1, 1);
    send_pixel(0, 0, 16'h1234);
    send_pixel(80, 0, 16'h8001);
    send_pixel(0, 45, 16'h7FFE);
    send_pixel(80, 45, 16'hC3C3);
    drain_writes();

    // Height fit is too wide, so the width fit takes over.
    set_mode(1, 200, 100);
    send_pixel(199, 99, 16'h3C3C);
    send_pixel(0, 0, 16'hFFFF);
    drain_writes();

    // A zero height counts as one.
    set_mode(1, 1280, 0);
    send_pixel(1279, 0, 16'h00FF);
    send_pixel(1279, 1, 16'hFF00);
    drain_writes();

    set_mode(0, 0, 720);
    send_pixel(0, 719, 16'h5555);
    send_pixel(1, 719, 16'hAAAA);
    drain_writes();

    set_mode(0, 2047, 1023);
    send_pixel(1279, 719, 16'h1111);
    send_pixel(1024, 0, 16'h2222);
    drain_writes();

    for (int phase = 0; phase < 8; phase++) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      set_mode($urandom_range(0, 1), draw_size(1280, 2047), draw_size(720, 1023));
      for (int k = 0; k < 48; k++) begin
        if (phase == 2 && k == 24) begin
          drain_writes();
        end
        random_pixel();
      end
      drain_writes();
    end

    if (frame_writes.errors == 0 && frame_writes.pending.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
